// File: sv/x86_multiply_divide_unit_assert.svh
// Assertion macros shared by the checker files.
// Depends on nothing; included by x86_multiply_divide_unit_chk.sv.
`ifndef X86_MULTIPLY_DIVIDE_UNIT_ASSERT_SVH
`define X86_MULTIPLY_DIVIDE_UNIT_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define XMDU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xmdu check failed");

// next-cycle implication checked outside reset
`define XMDU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xmdu check failed");

`endif

// File: sv/xmdu_pkg.sv
// Shared types and constants of the x86 multiply/divide unit.
// No dependencies.
package xmdu_pkg;

  localparam logic [2:0] OP_MUL   = 3'd0;
  localparam logic [2:0] OP_IMUL1 = 3'd1;
  localparam logic [2:0] OP_IMUL2 = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_IDIV  = 3'd4;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_WORD = 2'd1;

  // divide-pipeline item: p holds {remainder, dividend/quotient} or the product
  typedef struct packed {
    logic        vld;
    logic [2:0]  op;
    logic [1:0]  sz;
    logic        neg_q;
    logic        neg_r;
    logic        err;
    logic [31:0] mv;
    logic [63:0] p;
  } st_t;

  function automatic logic [31:0] size_mask(input logic [1:0] sz);
    case (sz)
      SZ_BYTE: size_mask = 32'h0000_00FF;
      SZ_WORD: size_mask = 32'h0000_FFFF;
      default: size_mask = 32'hFFFF_FFFF;
    endcase
  endfunction

endpackage

// File: sv/x86_multiply_divide_unit.sv
// x86 MUL/IMUL/DIV/IDIV execution unit, fully pipelined.
// Stages: prep, multiply or range check, 32 restoring divide steps, output.
// Throughput: one item per cycle while the output is not stalled.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// rst_n (synchronous, active low) clears all stage valid bits.
// Depends on xmdu_pkg.
module x86_multiply_divide_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [1:0]  in_operand_size,
  input  logic [31:0] in_acc_low,
  input  logic [31:0] in_acc_high,
  input  logic [31:0] in_op_a,
  input  logic [31:0] in_op_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_low,
  output logic [31:0] out_result_high,
  output logic        out_carry_overflow,
  output logic        out_flags_written,
  output logic        out_divide_error
);

  localparam int Steps = 32;

  // Global advance: every stage moves when the output slot is free or taken.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---------------------------------------------------------------- stage 0
  // Mask operands, extend multiply factors to 33 bits, build divide magnitudes.
  logic               s0_vld_r;
  logic [2:0]         s0_op_r;
  logic [1:0]         s0_sz_r;
  logic signed [32:0] s0_x_r, s0_y_r;
  logic [63:0]        s0_md_r;
  logic [31:0]        s0_mv_r;
  logic               s0_nd_r, s0_nv_r, s0_zero_r;

  logic [31:0]        m, a_m, b_m, acc_m, hi_m;
  logic signed [32:0] x_nxt, y_nxt;
  logic [63:0]        dvd, md_nxt;
  logic [31:0]        mv_nxt;
  logic               nd_nxt, nv_nxt, sgn;

  always_comb begin
    m     = xmdu_pkg::size_mask(in_operand_size);
    a_m   = in_op_a & m;
    b_m   = in_op_b & m;
    acc_m = in_acc_low & m;
    hi_m  = in_acc_high & m;
    sgn   = (in_operation != xmdu_pkg::OP_MUL);
    case (in_operand_size)
      xmdu_pkg::SZ_BYTE: begin
        x_nxt  = {{25{sgn & a_m[7]}}, a_m[7:0]};
        y_nxt  = (in_operation == xmdu_pkg::OP_IMUL2) ? {{25{b_m[7]}}, b_m[7:0]}
                                                       : {{25{sgn & acc_m[7]}}, acc_m[7:0]};
        dvd    = {48'd0, in_acc_low[15:0]};
        nd_nxt = dvd[15];
        md_nxt = nd_nxt ? {48'd0, 16'(-dvd[15:0])} : dvd;
        nv_nxt = a_m[7];
        mv_nxt = nv_nxt ? {24'd0, 8'(-a_m[7:0])} : a_m;
      end
      xmdu_pkg::SZ_WORD: begin
        x_nxt  = {{17{sgn & a_m[15]}}, a_m[15:0]};
        y_nxt  = (in_operation == xmdu_pkg::OP_IMUL2) ? {{17{b_m[15]}}, b_m[15:0]}
                                                       : {{17{sgn & acc_m[15]}}, acc_m[15:0]};
        dvd    = {32'd0, hi_m[15:0], acc_m[15:0]};
        nd_nxt = dvd[31];
        md_nxt = nd_nxt ? {32'd0, 32'(-dvd[31:0])} : dvd;
        nv_nxt = a_m[15];
        mv_nxt = nv_nxt ? {16'd0, 16'(-a_m[15:0])} : a_m;
      end
      default: begin
        x_nxt  = {sgn & a_m[31], a_m};
        y_nxt  = (in_operation == xmdu_pkg::OP_IMUL2) ? {b_m[31], b_m}
                                                       : {sgn & acc_m[31], acc_m};
        dvd    = {hi_m, acc_m};
        nd_nxt = dvd[63];
        md_nxt = nd_nxt ? (-dvd) : dvd;
        nv_nxt = a_m[31];
        mv_nxt = nv_nxt ? (-a_m) : a_m;
      end
    endcase
    // unsigned DIV takes raw values
    if (in_operation != xmdu_pkg::OP_IDIV) begin
      nd_nxt = 1'b0;
      nv_nxt = 1'b0;
      md_nxt = dvd;
      mv_nxt = a_m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_valid;
    end
    if (adv) begin
      s0_op_r   <= in_operation;
      s0_sz_r   <= in_operand_size;
      s0_x_r    <= x_nxt;
      s0_y_r    <= y_nxt;
      s0_md_r   <= md_nxt;
      s0_mv_r   <= mv_nxt;
      s0_nd_r   <= nd_nxt;
      s0_nv_r   <= nv_nxt;
      s0_zero_r <= (a_m == 32'd0);
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Multiply, or check that the quotient fits the operand size.
  xmdu_pkg::st_t      div_r [0:Steps];
  xmdu_pkg::st_t      s1_nxt;
  logic signed [65:0] prod;
  logic [31:0]        md_top;
  logic               is_div;

  always_comb begin
    prod   = s0_x_r * s0_y_r;
    is_div = (s0_op_r == xmdu_pkg::OP_DIV) || (s0_op_r == xmdu_pkg::OP_IDIV);
    case (s0_sz_r)
      xmdu_pkg::SZ_BYTE: md_top = {24'd0, s0_md_r[15:8]};
      xmdu_pkg::SZ_WORD: md_top = {16'd0, s0_md_r[31:16]};
      default:           md_top = s0_md_r[63:32];
    endcase
    s1_nxt.vld   = s0_vld_r;
    s1_nxt.op    = s0_op_r;
    s1_nxt.sz    = s0_sz_r;
    s1_nxt.neg_q = s0_nd_r ^ s0_nv_r;
    s1_nxt.neg_r = s0_nd_r;
    s1_nxt.err   = is_div && (s0_zero_r || (md_top >= s0_mv_r));
    s1_nxt.mv    = s0_mv_r;
    s1_nxt.p     = is_div ? s0_md_r : prod[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r[0].vld <= 1'b0;
    end else if (adv) begin
      div_r[0].vld <= s1_nxt.vld;
    end
    if (adv) begin
      div_r[0].op    <= s1_nxt.op;
      div_r[0].sz    <= s1_nxt.sz;
      div_r[0].neg_q <= s1_nxt.neg_q;
      div_r[0].neg_r <= s1_nxt.neg_r;
      div_r[0].err   <= s1_nxt.err;
      div_r[0].mv    <= s1_nxt.mv;
      div_r[0].p     <= s1_nxt.p;
    end
  end

  // ---------------------------------------------------------- divide steps
  // One restoring step per stage; multiplies and errored items pass unchanged.
  function automatic xmdu_pkg::st_t div_step(input xmdu_pkg::st_t s);
    xmdu_pkg::st_t o;
    logic [32:0]   t;
    logic [32:0]   d;
    o = s;
    t = {s.p[63:32], s.p[31]};
    d = t - {1'b0, s.mv};
    if ((s.op == xmdu_pkg::OP_DIV || s.op == xmdu_pkg::OP_IDIV) && !s.err) begin
      if (!d[32]) begin
        o.p = {d[31:0], s.p[30:0], 1'b1};
      end else begin
        o.p = {t[31:0], s.p[30:0], 1'b0};
      end
    end
    return o;
  endfunction

  for (genvar k = 0; k < Steps; k++) begin : g_div
    xmdu_pkg::st_t nx;
    assign nx = div_step(div_r[k]);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_r[k+1].vld <= 1'b0;
      end else if (adv) begin
        div_r[k+1].vld <= nx.vld;
      end
      if (adv) begin
        div_r[k+1].op    <= nx.op;
        div_r[k+1].sz    <= nx.sz;
        div_r[k+1].neg_q <= nx.neg_q;
        div_r[k+1].neg_r <= nx.neg_r;
        div_r[k+1].err   <= nx.err;
        div_r[k+1].mv    <= nx.mv;
        div_r[k+1].p     <= nx.p;
      end
    end
  end

  // ------------------------------------------------------------ output stage
  // Split the product, fix signs of quotient/remainder, final IDIV range check.
  xmdu_pkg::st_t f;
  logic [31:0]   fm, lo_nxt, hi_nxt, q, r, lim, ph;
  logic          cf_nxt, fw_nxt, de_nxt, fits;

  always_comb begin
    f      = div_r[Steps];
    fm     = xmdu_pkg::size_mask(f.sz);
    q      = f.p[31:0];
    r      = f.p[63:32];
    lo_nxt = 32'd0;
    hi_nxt = 32'd0;
    cf_nxt = 1'b0;
    fw_nxt = 1'b0;
    de_nxt = 1'b0;
    case (f.sz)
      xmdu_pkg::SZ_BYTE: begin
        ph   = {24'd0, f.p[15:8]};
        fits = (f.p[63:7] == {57{f.p[7]}});
        lim  = f.neg_q ? 32'h80 : 32'h7F;
      end
      xmdu_pkg::SZ_WORD: begin
        ph   = {16'd0, f.p[31:16]};
        fits = (f.p[63:15] == {49{f.p[15]}});
        lim  = f.neg_q ? 32'h8000 : 32'h7FFF;
      end
      default: begin
        ph   = f.p[63:32];
        fits = (f.p[63:31] == {33{f.p[31]}});
        lim  = f.neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
    endcase
    case (f.op)
      xmdu_pkg::OP_MUL: begin
        lo_nxt = f.p[31:0] & fm;
        hi_nxt = ph;
        cf_nxt = (ph != 32'd0);
        fw_nxt = 1'b1;
      end
      xmdu_pkg::OP_IMUL1: begin
        lo_nxt = f.p[31:0] & fm;
        hi_nxt = ph;
        cf_nxt = !fits;
        fw_nxt = 1'b1;
      end
      xmdu_pkg::OP_IMUL2: begin
        lo_nxt = f.p[31:0] & fm;
        cf_nxt = !fits;
        fw_nxt = 1'b1;
      end
      xmdu_pkg::OP_DIV: begin
        if (f.err) begin
          de_nxt = 1'b1;
        end else begin
          lo_nxt = q;
          hi_nxt = r;
        end
      end
      xmdu_pkg::OP_IDIV: begin
        if (f.err || (q > lim)) begin
          de_nxt = 1'b1;
        end else begin
          lo_nxt = f.neg_q ? ((-q) & fm) : q;
          hi_nxt = f.neg_r ? ((-r) & fm) : r;
        end
      end
      default: ;
    endcase
  end

  logic        ov_r;
  logic [31:0] lo_r, hi_r;
  logic        cf_r, fw_r, de_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= f.vld;
    end
    if (adv) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
      cf_r <= cf_nxt;
      fw_r <= fw_nxt;
      de_r <= de_nxt;
    end
  end

  assign out_valid          = ov_r;
  assign out_result_low     = lo_r;
  assign out_result_high    = hi_r;
  assign out_carry_overflow = cf_r;
  assign out_flags_written  = fw_r;
  assign out_divide_error   = de_r;

endmodule

// File: sv/x86_multiply_divide_unit_chk.sv
// Port-level checker for the x86 multiply/divide unit, with its bind.
// Depends on x86_multiply_divide_unit_assert.svh.
`include "x86_multiply_divide_unit_assert.svh"

module x86_multiply_divide_unit_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result_low,
  input logic [31:0] out_result_high,
  input logic        out_carry_overflow,
  input logic        out_flags_written,
  input logic        out_divide_error
);

  `XMDU_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_result_low))
  `XMDU_ASSERT_IMPL(a_err_zero, out_valid && out_divide_error,
                    out_result_low == 32'd0 && out_result_high == 32'd0 && !out_carry_overflow)
  `XMDU_ASSERT_IMPL(a_err_noflag, out_valid && out_divide_error, !out_flags_written)
  `XMDU_ASSERT_IMPL(a_cf_mul, out_valid && out_carry_overflow, out_flags_written)
  `XMDU_ASSERT_IMPL(a_stall, out_valid && !out_ready, !in_ready)

endmodule

bind x86_multiply_divide_unit x86_multiply_divide_unit_chk u_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_result_low     (out_result_low),
  .out_result_high    (out_result_high),
  .out_carry_overflow (out_carry_overflow),
  .out_flags_written  (out_flags_written),
  .out_divide_error   (out_divide_error)
);

// File: verif/tb.sv
// Testbench for x86_multiply_divide_unit: directed and random MUL/IMUL/DIV/IDIV items,
// checked against an in-bench arithmetic predictor through a small scoreboard class.
// Depends on xmdu_pkg and the RTL top level.
`timescale 1ns / 100ps

module tb;

  // one expected or observed result item
  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
    logic        cf;
    logic        fw;
    logic        de;
  } mdu_res_t;

  // local name for the doubleword size code (package only has byte/word)
  localparam logic [1:0] SZ_DWORD = 2'd2;
  localparam logic [1:0] SZ_ALIAS = 2'd3;

  // scoreboard: predicts each accepted item, checks results in order
  class mdu_scoreboard;
    mdu_res_t pending[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    // sign-extend the low n bits of v to 64
    function automatic logic signed [63:0] sx(logic [63:0] v, int n);
      logic [63:0] s;
      s = 64'd1 << (n - 1);
      v = v & ((64'd1 << n) - 1);
      return $signed((v ^ s) - s);
    endfunction

    function automatic mdu_res_t compute(logic [2:0] op, logic [1:0] sz, logic [31:0] al,
                                         logic [31:0] ah, logic [31:0] oa, logic [31:0] ob);
      mdu_res_t r;
      int n;
      logic [63:0] m, m2, acc, a, b, p, dvd, md, mv, q, rm, lim;
      logic signed [63:0] sp;
      logic nd, nv, nq;
      r = '0;
      n = (sz == xmdu_pkg::SZ_BYTE) ? 8 : (sz == xmdu_pkg::SZ_WORD) ? 16 : 32;
      m = (64'd1 << n) - 1;
      acc = 64'(al) & m;
      a = 64'(oa) & m;
      b = 64'(ob) & m;
      case (op)
        xmdu_pkg::OP_MUL: begin
          p = a * acc;
          r.lo = 32'(p & m);
          r.hi = 32'((p >> n) & m);
          r.cf = r.hi != 0;
          r.fw = 1'b1;
        end
        xmdu_pkg::OP_IMUL1, xmdu_pkg::OP_IMUL2: begin
          sp = (op == xmdu_pkg::OP_IMUL1) ? sx(a, n) * sx(acc, n) : sx(a, n) * sx(b, n);
          r.lo = 32'(sp & m);
          r.hi = (op == xmdu_pkg::OP_IMUL1) ? 32'((sp >> n) & m) : 32'd0;
          r.cf = sp != sx(64'(r.lo), n);
          r.fw = 1'b1;
        end
        xmdu_pkg::OP_DIV, xmdu_pkg::OP_IDIV: begin
          m2 = (n == 32) ? '1 : ((64'd1 << (2 * n)) - 1);
          dvd = (n == 8) ? (64'(al) & 64'hFFFF) : (((64'(ah) & m) << n) | acc);
          if (a == 0) begin
            r.de = 1'b1;
          end else if (op == xmdu_pkg::OP_DIV) begin
            q = dvd / a;
            if (q > m) r.de = 1'b1;
            else begin
              r.lo = 32'(q);
              r.hi = 32'(dvd % a);
            end
          end else begin
            nd = dvd[2 * n - 1];
            nv = a[n - 1];
            md = nd ? ((0 - dvd) & m2) : dvd;
            mv = nv ? ((0 - a) & m) : a;
            q = md / mv;
            rm = md % mv;
            nq = nd != nv;
            lim = (64'd1 << (n - 1)) - (nq ? 0 : 1);
            if (q > lim) r.de = 1'b1;
            else begin
              r.lo = 32'(nq ? ((0 - q) & m) : q);
              r.hi = 32'(nd ? ((0 - rm) & m) : rm);
            end
          end
        end
        default: r = '0;  // undefined opcodes produce an all-zero result
      endcase
      return r;
    endfunction

    function void note_item(logic [2:0] op, logic [1:0] sz, logic [31:0] al,
                            logic [31:0] ah, logic [31:0] oa, logic [31:0] ob);
      pending.push_back(compute(op, sz, al, ah, oa, ob));
    endfunction

    function void check_result(mdu_res_t got);
      mdu_res_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result item, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.lo !== want.lo) begin
        $display("%0t: result_low expected %h actual %h", $time, want.lo, got.lo);
        errors++;
      end
      if (got.hi !== want.hi) begin
        $display("%0t: result_high expected %h actual %h", $time, want.hi, got.hi);
        errors++;
      end
      if (got.cf !== want.cf) begin
        $display("%0t: carry_overflow expected %b actual %b", $time, want.cf, got.cf);
        errors++;
      end
      if (got.fw !== want.fw) begin
        $display("%0t: flags_written expected %b actual %b", $time, want.fw, got.fw);
        errors++;
      end
      if (got.de !== want.de) begin
        $display("%0t: divide_error expected %b actual %b", $time, want.de, got.de);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_operation = '0;
  logic [1:0]  in_operand_size = '0;
  logic [31:0] in_acc_low = '0;
  logic [31:0] in_acc_high = '0;
  logic [31:0] in_op_a = '0;
  logic [31:0] in_op_b = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_result_low;
  logic [31:0] out_result_high;
  logic        out_carry_overflow;
  logic        out_flags_written;
  logic        out_divide_error;

  mdu_scoreboard board = new();
  bit     stim_done = 1'b0;
  longint cycle_count = 0;

  localparam longint CYCLE_LIMIT = 200000;
  localparam int     PIPE_LAT    = 35;

  always #2 clk = ~clk;

  x86_multiply_divide_unit dut (.*);

  // timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: accept and check; random stalls before each item, with calm stretches
  initial begin : sink
    int stall;
    int calm;
    calm = 0;
    @(posedge rst_n);
    forever begin
      stall = (calm > 0) ? 0 : $urandom_range(0, 4);
      if (calm > 0) calm--;
      else if ($urandom_range(0, 60) == 0) calm = $urandom_range(20, 80);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_result({out_result_low, out_result_high, out_carry_overflow,
                          out_flags_written, out_divide_error});
    end
  end

  // present one item, hold it until accepted; drops valid only for a gap
  task automatic send_item(logic [2:0] op, logic [1:0] sz, logic [31:0] al,
                           logic [31:0] ah, logic [31:0] oa, logic [31:0] ob, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_operand_size <= sz;
    in_acc_low      <= al;
    in_acc_high     <= ah;
    in_op_a         <= oa;
    in_op_b         <= ob;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_item(op, sz, al, ah, oa, ob);
  endtask

  // random operand biased toward edge values of the chosen size
  function automatic logic [31:0] pick_val(logic [1:0] sz);
    logic [31:0] msb;
    msb = (sz == xmdu_pkg::SZ_BYTE) ? 32'h80 :
          (sz == xmdu_pkg::SZ_WORD) ? 32'h8000 : 32'h8000_0000;
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return msb;
      4: return msb - 1;
      5: return $urandom_range(0, 7);
      default: return $urandom();
    endcase
  endfunction

  initial begin : driver
    logic [2:0]  op;
    logic [1:0]  sz;
    logic [31:0] a, dh, dl, q, am;
    int          gap;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: size extremes, each operation, error and overflow corners
    send_item(xmdu_pkg::OP_MUL,   xmdu_pkg::SZ_BYTE, 32'hFF, 0, 32'hFF, 0, 0);
    send_item(xmdu_pkg::OP_MUL,   SZ_DWORD, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0, 0);
    send_item(xmdu_pkg::OP_MUL,   xmdu_pkg::SZ_WORD, 32'hFFFF_0003, 0, 32'h0000_0005, 0, 0);
    send_item(xmdu_pkg::OP_IMUL1, xmdu_pkg::SZ_BYTE, 32'h80, 0, 32'h80, 0, 0);
    send_item(xmdu_pkg::OP_IMUL1, SZ_DWORD, 32'h8000_0000, 0, 32'hFFFF_FFFF, 0, 1);
    send_item(xmdu_pkg::OP_IMUL1, xmdu_pkg::SZ_WORD, 32'hFFFF, 0, 32'h0002, 0, 0);
    send_item(xmdu_pkg::OP_IMUL2, xmdu_pkg::SZ_WORD, 0, 32'hFFFF_FFFF, 32'h7FFF, 32'h7FFF, 0);
    send_item(xmdu_pkg::OP_IMUL2, SZ_DWORD, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_item(xmdu_pkg::OP_IMUL2, xmdu_pkg::SZ_BYTE, 0, 0, 32'h80, 32'hFF, 2);
    // quotient too big, then largest fitting
    send_item(xmdu_pkg::OP_DIV,   xmdu_pkg::SZ_BYTE, 32'h0000_FFFF, 0, 32'hFF, 0, 0);
    send_item(xmdu_pkg::OP_DIV,   xmdu_pkg::SZ_BYTE, 32'h0000_FEFF, 0, 32'hFF, 0, 0);
    // zero divisor
    send_item(xmdu_pkg::OP_DIV,   xmdu_pkg::SZ_WORD, 32'h1234, 32'h1, 0, 0, 0);
    send_item(xmdu_pkg::OP_DIV,   SZ_DWORD, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 0, 0);
    // -32768/-1 overflows, -128/1 fits
    send_item(xmdu_pkg::OP_IDIV,  xmdu_pkg::SZ_BYTE, 32'h0000_8000, 0, 32'hFF, 0, 0);
    send_item(xmdu_pkg::OP_IDIV,  xmdu_pkg::SZ_BYTE, 32'h0000_FF80, 0, 32'h01, 0, 0);
    // -7/2
    send_item(xmdu_pkg::OP_IDIV,  xmdu_pkg::SZ_WORD, 32'h0000_FFF9, 32'hFFFF, 32'h2, 0, 0);
    send_item(xmdu_pkg::OP_IDIV,  SZ_DWORD, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0);
    // 7/-2
    send_item(xmdu_pkg::OP_IDIV,  SZ_DWORD, 32'h0000_0007, 0, 32'hFFFF_FFFE, 0, 0);
    send_item(xmdu_pkg::OP_IDIV,  xmdu_pkg::SZ_WORD, 32'h5, 0, 0, 0, 0);
    // size 3 = dword
    send_item(xmdu_pkg::OP_MUL,   SZ_ALIAS, 32'h1234_5678, 0, 32'h9ABC_DEF0, 0, 0);
    send_item(xmdu_pkg::OP_DIV,   SZ_ALIAS, 32'h10, 32'h0, 32'h3, 0, 0);
    send_item(3'd5, xmdu_pkg::SZ_WORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h1, 0);
    send_item(3'd6, xmdu_pkg::SZ_BYTE, 32'h1, 32'h1, 32'h1, 32'h1, 0);
    send_item(3'd7, SZ_DWORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);

    // hold off until the pipeline has fully drained
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);

    for (int i = 0; i < 1250; i++) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 0;
      sz  = 2'($urandom_range(0, 3));
      op  = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      a   = pick_val(sz);
      if ((op == xmdu_pkg::OP_DIV || op == xmdu_pkg::OP_IDIV) && $urandom_range(0, 2) != 0) begin
        // build a dividend whose quotient mostly fits, so real quotients dominate
        if (a == 0) a = $urandom_range(1, 255);
        q  = $urandom();
        q  = (sz == xmdu_pkg::SZ_BYTE) ? (q & 32'h7F) :
             (sz == xmdu_pkg::SZ_WORD) ? (q & 32'h7FFF) : (q & 32'h7FFF_FFFF);
        am = a & xmdu_pkg::size_mask(sz);
        {dh, dl} = 64'(q) * 64'(am) + (64'($urandom()) % 64'(am | 32'd1));
        if (sz == xmdu_pkg::SZ_BYTE) begin
          dl = ($urandom() & 32'hFFFF_0000) | {16'h0, dl[15:0]};
          send_item(op, sz, dl, $urandom(), a, $urandom(), gap);
        end else if (sz == xmdu_pkg::SZ_WORD) begin
          send_item(op, sz, ($urandom() & 32'hFFFF_0000) | {16'h0, dl[15:0]},
                    ($urandom() & 32'hFFFF_0000) | {16'h0, dl[31:16]}, a, $urandom(), gap);
        end else begin
          send_item(op, sz, dl, dh, a, $urandom(), gap);
        end
      end else begin
        send_item(op, sz, pick_val(sz), pick_val(sz), a, pick_val(sz), gap);
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // end of run: drain, then wait for stray results
  initial begin : finisher
    wait (stim_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4 * PIPE_LAT) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
